@@ hw/rtl/mtfkv_pkg.sv @@
// Shared types and constants for the move-to-front key/value table.
package mtfkv_pkg;

  localparam int FIELD_WIDTH = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_code_t;

  typedef struct packed {
    logic [1:0]             command;
    logic [FIELD_WIDTH-1:0] key;
    logic [FIELD_WIDTH-1:0] value_in;
  } req_t;

  typedef struct packed {
    logic                   hit;
    logic [FIELD_WIDTH-1:0] value_out;
    logic                   table_empty;
    logic                   full_error;
  } rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic take;   // latch request, compare against all live entries
    logic exec;   // apply insert or lookup and load the result register
    logic step;   // delete the frontmost remaining match
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic any_match;
  } dp_status_t;

endpackage

@@ hw/rtl/mtfkv_datapath.sv @@
// Entry storage, match vector, shift network and result register.
module mtfkv_datapath import mtfkv_pkg::*; #(
  parameter int DEPTH       = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  req_t       req,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output rsp_t       rsp
);

  localparam int KW    = (KEY_WIDTH < FIELD_WIDTH) ? KEY_WIDTH : FIELD_WIDTH;
  localparam int VW    = (VALUE_WIDTH < FIELD_WIDTH) ? VALUE_WIDTH : FIELD_WIDTH;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [KW-1:0]    keys [DEPTH];
  logic [VW-1:0]    vals [DEPTH];
  logic [CNT_W-1:0] count;
  logic [DEPTH-1:0] match;
  logic [1:0]       req_cmd;
  logic [KW-1:0]    req_key;
  logic [VW-1:0]    req_val;
  logic             hit_seen;

  logic [DEPTH-1:0] live;
  logic [DEPTH-1:0] eq;
  logic [DEPTH-1:0] first;
  logic [DEPTH-1:0] ahead;
  logic [DEPTH-1:0] upto;
  logic [VW-1:0]    found_val;
  logic             any_match;
  logic             full;
  logic             do_insert;
  logic             do_move;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      live[i] = CNT_W'(i) < count;
      eq[i]   = live[i] && (keys[i] == req.key[KW-1:0]);
    end
  end

  assign any_match = |match;
  assign first     = match & (~match + DEPTH'(1));
  assign ahead     = first - DEPTH'(1);
  assign upto      = ahead | first;
  assign full      = count == CNT_W'(DEPTH);
  assign do_insert = cmd.exec && (req_cmd == CMD_INSERT) && !full;
  assign do_move   = cmd.exec && (req_cmd == CMD_LOOKUP) && any_match;

  always_comb begin
    found_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      found_val = found_val | ({VW{first[i]}} & vals[i]);
    end
  end

  // Entry array: shift back on insert and move-to-front, pull forward on delete.
  always_ff @(posedge clk) begin
    if (do_insert) begin
      keys[0] <= req_key;
      vals[0] <= req_val;
      for (int i = 1; i < DEPTH; i++) begin
        keys[i] <= keys[i-1];
        vals[i] <= vals[i-1];
      end
    end else if (do_move) begin
      keys[0] <= req_key;
      vals[0] <= found_val;
      for (int i = 1; i < DEPTH; i++) begin
        if (upto[i]) begin
          keys[i] <= keys[i-1];
          vals[i] <= vals[i-1];
        end
      end
    end else if (cmd.step) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (!ahead[i]) begin
          keys[i] <= keys[i+1];
          vals[i] <= vals[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      match    <= '0;
      hit_seen <= 1'b0;
    end else begin
      if (cmd.take) begin
        match    <= eq;
        hit_seen <= 1'b0;
      end else if (cmd.step) begin
        match    <= (match & ahead) | ((match >> 1) & ~ahead);
        hit_seen <= 1'b1;
      end
      if (do_insert) begin
        count <= count + CNT_W'(1);
      end else if (cmd.step) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_cmd <= req.command;
      req_key <= req.key[KW-1:0];
      req_val <= req.value_in[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      case (req_cmd)
        CMD_INSERT: begin
          rsp.hit         <= 1'b0;
          rsp.value_out   <= '0;
          rsp.table_empty <= 1'b0;
          rsp.full_error  <= full;
        end
        CMD_LOOKUP: begin
          rsp.hit         <= any_match;
          rsp.value_out   <= any_match ? FIELD_WIDTH'(found_val) : '0;
          rsp.table_empty <= count == '0;
          rsp.full_error  <= 1'b0;
        end
        default: begin
          rsp.hit         <= hit_seen;
          rsp.value_out   <= '0;
          rsp.table_empty <= count == '0;
          rsp.full_error  <= 1'b0;
        end
      endcase
    end
  end

  assign status.any_match = any_match;

endmodule

@@ hw/rtl/mtfkv_ctrl.sv @@
// Control state machine and result-valid flag for the move-to-front table.
module mtfkv_ctrl import mtfkv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [1:0] req_command,
  output logic       req_ready,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_EXEC   = 3'b010,
    ST_REMOVE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = state == ST_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.take   = 1'b1;
          state_next = (req_command == CMD_REMOVE) ? ST_REMOVE : ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_REMOVE: begin
        if (status.any_match) begin
          cmd.step = 1'b1;
        end else if (out_free) begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.exec) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/move_to_front_key_value_table.sv @@
// Top level of the move-to-front key/value table: controller plus datapath.
//
//   channel  signals                     payload  direction
//   req      req_valid / req_ready       req_t    into block
//   rsp      rsp_valid / rsp_ready       rsp_t    out of block
//
// Insert and lookup first latch the request and compare the key against every
// live entry at once, then shift the entry row and load the result register.
// Remove compares the same way; the delete network then closes one gap per cycle
// until no match remains, and the result register is loaded.
// Reset (rst, synchronous) empties the table; entry contents are not cleared.
// A waiting result holds in the result register; a finished item stalls only
// while the previous result is still untaken.
module move_to_front_key_value_table import mtfkv_pkg::*; #(
  parameter int DEPTH       = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequence each request: compare, then insert/move or step through deletes.
  mtfkv_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_command (req.command),
    .req_ready   (req_ready),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .status      (status),
    .cmd         (cmd)
  );

  // Hold entries, match vector and the result register.
  mtfkv_datapath #(
    .DEPTH       (DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .status (status),
    .rsp    (rsp)
  );

  // Block is busy right after a request transfer.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while previous one still in progress");

  // A refused insert never reports a hit.
  a_full_no_hit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.full_error && rsp.hit))
    else $error("full_error and hit both set");

  // Only a lookup hit returns a nonzero value.
  a_value_needs_hit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.value_out != '0) |-> rsp.hit)
    else $error("nonzero value without hit");

  // A delete step only happens while a match remains.
  a_step_on_match: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> status.any_match && !req_ready)
    else $error("delete step without pending match");

endmodule
